// File: src/erf_pkg.sv
package erf_pkg;

   localparam int OPCODE_W = 3;
   localparam int TIME_W   = 16;
   localparam int DIST_W   = 17;
   localparam int SPEED_W  = 12;
   localparam int ALPHA_W  = 9;
   localparam int Q_SHIFT  = 8;

   localparam int MEDIAN_DEPTH = 5;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   localparam logic [OPCODE_W-1:0] OP_TRIGGER   = 3'd0;
   localparam logic [OPCODE_W-1:0] OP_ECHO      = 3'd1;
   localparam logic [OPCODE_W-1:0] OP_POLL      = 3'd2;
   localparam logic [OPCODE_W-1:0] OP_CALIBRATE = 3'd3;
   localparam logic [OPCODE_W-1:0] OP_READ      = 3'd4;

   localparam logic [TIME_W-1:0]  RST_MIN_PULSE  = 16'd233;
   localparam logic [TIME_W-1:0]  RST_MAX_PULSE  = 16'd23300;
   localparam logic [TIME_W-1:0]  RST_TIMER_PER  = 16'd20000;
   localparam logic [SPEED_W-1:0] RST_SPEED      = 12'd1124;
   localparam logic [DIST_W-1:0]  RST_SPIKE      = 17'd6400;
   localparam logic [ALPHA_W-1:0] RST_ALPHA      = 9'd77;
   localparam logic [TIME_W-1:0]  RST_TIMEOUT    = 16'd30;

   typedef struct packed {
      logic [TIME_W-1:0]  min_pulse_us;
      logic [TIME_W-1:0]  max_pulse_us;
      logic [TIME_W-1:0]  timer_period;
      logic [SPEED_W-1:0] speed_factor_q8;
      logic [DIST_W-1:0]  spike_threshold_q8;
      logic [ALPHA_W-1:0] lpf_alpha_q8;
      logic [TIME_W-1:0]  timeout_ms;
   } cfg_type;

   typedef struct packed {
      logic accept;
      logic trig;
      logic edge_rise;
      logic edge_fall;
      logic timeout;
      logic calibrate;
      logic take;
      logic invalidate;
      logic scale;
      logic set_valid;
      logic commit;
      logic med_next;
      logic med_take;
      logic ema_load;
      logic ema_mul_a;
      logic ema_mul_b;
      logic ema_sum;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic phase_idle;
      logic phase_rise;
      logic phase_fall;
      logic cap_ready;
      logic timeout_hit;
      logic gate_ok;
      logic spike;
      logic med_hit;
      logic ema_direct;
   } stat_type;

endpackage

// File: src/erf_ctrl.sv
module erf_ctrl (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [erf_pkg::OPCODE_W-1:0]   req_opcode,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output erf_pkg::cmd_type               cmd,
   input  erf_pkg::stat_type              st
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_GATE  = 3'd1;
   localparam logic [2:0] S_CHECK = 3'd2;
   localparam logic [2:0] S_MED   = 3'd3;
   localparam logic [2:0] S_EMA1  = 3'd4;
   localparam logic [2:0] S_EMA2  = 3'd5;
   localparam logic [2:0] S_EMA3  = 3'd6;
   localparam logic [2:0] S_EMIT  = 3'd7;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready    = (state_ff == S_IDLE);
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = S_EMIT;
               unique case (req_opcode)
                  erf_pkg::OP_TRIGGER: cmd.trig = st.phase_idle;
                  erf_pkg::OP_ECHO: begin
                     cmd.edge_rise = st.phase_rise;
                     cmd.edge_fall = st.phase_fall;
                  end
                  erf_pkg::OP_POLL: begin
                     if (st.cap_ready) begin
                        cmd.take = 1'b1;
                        state_in = S_GATE;
                     end else begin
                        cmd.timeout = !st.phase_idle && st.timeout_hit;
                     end
                  end
                  erf_pkg::OP_CALIBRATE: cmd.calibrate = 1'b1;
                  default: ;
               endcase
            end
         end
         S_GATE: begin
            if (st.gate_ok) begin
               cmd.scale = 1'b1;
               state_in  = S_CHECK;
            end else begin
               cmd.invalidate = 1'b1;
               state_in       = S_EMIT;
            end
         end
         S_CHECK: begin
            if (st.spike) begin
               cmd.set_valid = 1'b1;
               state_in      = S_EMIT;
            end else begin
               cmd.commit = 1'b1;
               state_in   = S_MED;
            end
         end
         S_MED: begin
            if (st.med_hit) begin
               cmd.med_take = 1'b1;
               state_in     = S_EMA1;
            end else begin
               cmd.med_next = 1'b1;
            end
         end
         S_EMA1: begin
            if (st.ema_direct) begin
               cmd.ema_load = 1'b1;
               state_in     = S_EMIT;
            end else begin
               cmd.ema_mul_a = 1'b1;
               state_in      = S_EMA2;
            end
         end
         S_EMA2: begin
            cmd.ema_mul_b = 1'b1;
            state_in      = S_EMA3;
         end
         S_EMA3: begin
            cmd.ema_sum = 1'b1;
            state_in    = S_EMIT;
         end
         S_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.emit     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// File: src/erf_dp.sv
module erf_dp #(
   parameter int MEDIAN_DEPTH = erf_pkg::MEDIAN_DEPTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [erf_pkg::TIME_W-1:0]    req_edge_time,
   input  logic [erf_pkg::TIME_W-1:0]    req_now_ms,
   input  erf_pkg::cfg_type              cfg,
   input  erf_pkg::cmd_type              cmd,
   output erf_pkg::stat_type             st,
   output logic [erf_pkg::DIST_W-1:0]    rsp_height_q8,
   output logic [erf_pkg::DIST_W-1:0]    rsp_distance_q8,
   output logic                          rsp_measure_valid,
   output logic                          rsp_busy_res,
   output logic                          rsp_fire_trigger
);

   localparam int TW      = erf_pkg::TIME_W;
   localparam int DW      = erf_pkg::DIST_W;
   localparam int AW      = erf_pkg::ALPHA_W;
   localparam int QS      = erf_pkg::Q_SHIFT;
   localparam int SCALE_W = erf_pkg::TIME_W + erf_pkg::SPEED_W;
   localparam int PROD_W  = erf_pkg::ALPHA_W + erf_pkg::DIST_W;
   localparam int SUM_W   = PROD_W + 1;
   localparam int POS_W   = $clog2(MEDIAN_DEPTH);
   localparam int CNT_W   = $clog2(MEDIAN_DEPTH + 1);

   localparam logic [POS_W-1:0] POS_LAST  = POS_W'(MEDIAN_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(MEDIAN_DEPTH);
   localparam logic [DW-1:0]    DIST_MAX  = {DW{1'b1}};
   localparam logic [AW-1:0]    ALPHA_ONE = AW'(1 << QS);
   localparam logic [SUM_W-1:0] ROUND     = SUM_W'(1 << (QS - 1));

   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_RISE = 2'd1;
   localparam logic [1:0] PH_FALL = 2'd2;

   logic [1:0]        phase_ff;
   logic              cap_ready_ff;
   logic [TW-1:0]     rise_ff, fall_ff, trig_ff;
   logic [DW-1:0]     width_ff, width_in;
   logic [DW-1:0]     raw_ff, raw_in;
   logic [DW-1:0]     last_ff;
   logic [DW-1:0]     win_ff [MEDIAN_DEPTH];
   logic [POS_W-1:0]  pos_ff, idx_ff;
   logic              full_ff;
   logic [DW-1:0]     med_ff;
   logic [DW-1:0]     sm_ff, held_ff, ground_ff;
   logic              valid_ff;
   logic              fire_pend_ff;
   logic [PROD_W-1:0] prod_a_ff, prod_b_ff;

   logic [TW-1:0]      elapsed;
   logic [SCALE_W-1:0] scale_prod;
   logic [DW-1:0]      diff;
   logic [CNT_W-1:0]   n_cnt, k_cnt, lt_cnt, le_cnt;
   logic [DW-1:0]      cand;
   logic [AW-1:0]      alpha_sat, alpha_rem;
   logic [SUM_W-1:0]   ema_sum;
   logic [DW-1:0]      ema_val;

   assign width_in = (fall_ff >= rise_ff) ? {1'b0, fall_ff - rise_ff}
                   : ({1'b0, cfg.timer_period} - {1'b0, rise_ff} + {1'b0, fall_ff});

   assign scale_prod = width_ff[TW-1:0] * cfg.speed_factor_q8;
   assign raw_in = (|scale_prod[SCALE_W-1:DW+QS]) ? DIST_MAX : scale_prod[DW+QS-1:QS];

   assign diff    = (raw_ff > last_ff) ? raw_ff - last_ff : last_ff - raw_ff;
   assign elapsed = req_now_ms - trig_ff;

   always_comb begin
      n_cnt  = full_ff ? CNT_FULL : CNT_W'(pos_ff);
      k_cnt  = n_cnt >> 1;
      cand   = win_ff[idx_ff];
      lt_cnt = '0;
      le_cnt = '0;
      for (int j = 0; j < MEDIAN_DEPTH; j++) begin
         if (full_ff || (POS_W'(j) < pos_ff)) begin
            lt_cnt = lt_cnt + CNT_W'(win_ff[j] < cand);
            le_cnt = le_cnt + CNT_W'(win_ff[j] <= cand);
         end
      end
   end

   assign alpha_sat = cfg.lpf_alpha_q8[AW-1] ? ALPHA_ONE : cfg.lpf_alpha_q8;
   assign alpha_rem = ALPHA_ONE - alpha_sat;
   assign ema_sum   = {1'b0, prod_a_ff} + {1'b0, prod_b_ff} + ROUND;
   assign ema_val   = (|ema_sum[SUM_W-1:DW+QS]) ? DIST_MAX : ema_sum[DW+QS-1:QS];

   always_comb begin
      st             = '0;
      st.phase_idle  = (phase_ff == PH_IDLE);
      st.phase_rise  = (phase_ff == PH_RISE);
      st.phase_fall  = (phase_ff == PH_FALL);
      st.cap_ready   = cap_ready_ff;
      st.timeout_hit = (elapsed >= cfg.timeout_ms);
      st.gate_ok     = (width_ff >= {1'b0, cfg.min_pulse_us})
                    && (width_ff <= {1'b0, cfg.max_pulse_us});
      st.spike       = (last_ff != '0) && (diff > cfg.spike_threshold_q8);
      st.med_hit     = (lt_cnt <= k_cnt) && (le_cnt > k_cnt);
      st.ema_direct  = (sm_ff[DW-1:QS] == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         cap_ready_ff <= 1'b0;
         rise_ff      <= '0;
         fall_ff      <= '0;
         trig_ff      <= '0;
      end else begin
         if (cmd.trig) begin
            cap_ready_ff <= 1'b0;
            phase_ff     <= PH_RISE;
            trig_ff      <= req_now_ms;
         end
         if (cmd.edge_rise) begin
            rise_ff  <= req_edge_time;
            phase_ff <= PH_FALL;
         end
         if (cmd.edge_fall) begin
            fall_ff      <= req_edge_time;
            cap_ready_ff <= 1'b1;
            phase_ff     <= PH_IDLE;
         end
         if (cmd.timeout) begin
            phase_ff <= PH_IDLE;
         end
         if (cmd.take) begin
            cap_ready_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff   <= '0;
         pos_ff    <= '0;
         full_ff   <= 1'b0;
         idx_ff    <= '0;
         sm_ff     <= '0;
         held_ff   <= '0;
         ground_ff <= '0;
         valid_ff  <= 1'b0;
      end else begin
         if (cmd.timeout || cmd.invalidate) begin
            valid_ff <= 1'b0;
         end
         if (cmd.set_valid) begin
            valid_ff <= 1'b1;
         end
         if (cmd.calibrate && valid_ff && (held_ff != '0)) begin
            ground_ff <= held_ff;
         end
         if (cmd.commit) begin
            last_ff <= raw_ff;
            idx_ff  <= '0;
            if (pos_ff == POS_LAST) begin
               pos_ff  <= '0;
               full_ff <= 1'b1;
            end else begin
               pos_ff <= pos_ff + 1'b1;
            end
         end
         if (cmd.med_next) begin
            idx_ff <= idx_ff + 1'b1;
         end
         if (cmd.ema_load) begin
            sm_ff    <= med_ff;
            held_ff  <= med_ff;
            valid_ff <= 1'b1;
         end
         if (cmd.ema_sum) begin
            sm_ff    <= ema_val;
            held_ff  <= ema_val;
            valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         win_ff[pos_ff] <= raw_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take) begin
         width_ff <= width_in;
      end
      if (cmd.scale) begin
         raw_ff <= raw_in;
      end
      if (cmd.med_take) begin
         med_ff <= cand;
      end
      if (cmd.ema_mul_a) begin
         prod_a_ff <= alpha_sat * med_ff;
      end
      if (cmd.ema_mul_b) begin
         prod_b_ff <= alpha_rem * sm_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fire_pend_ff <= 1'b0;
      end else if (cmd.accept) begin
         fire_pend_ff <= cmd.trig;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_height_q8     <= (held_ff > ground_ff) ? held_ff - ground_ff : '0;
         rsp_distance_q8   <= held_ff;
         rsp_measure_valid <= valid_ff;
         rsp_busy_res      <= (phase_ff != PH_IDLE);
         rsp_fire_trigger  <= fire_pend_ff;
      end
   end

   a_commit_fills: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> (full_ff || (pos_ff != '0)))
      else $error("median window empty after a commit");

   a_med_take_hit: assert property (@(posedge clock) disable iff (reset)
      cmd.med_take |-> st.med_hit)
      else $error("median taken from a candidate that is not the middle");

   a_ema_held: assert property (@(posedge clock) disable iff (reset)
      cmd.ema_sum |=> (valid_ff && (held_ff == sm_ff)))
      else $error("held distance out of step with the filter");

   a_fall_ready: assert property (@(posedge clock) disable iff (reset)
      cmd.edge_fall |=> (cap_ready_ff && (phase_ff == PH_IDLE)))
      else $error("falling edge did not leave a capture pending");

endmodule

// File: src/echo_range_filter.sv
// Channel   Direction  Handshake            Word
// req       in         req_valid/req_ready  opcode, edge_time, now_ms
// rsp       out        rsp_valid/rsp_ready  height, distance, valid, busy, fire
// csr       in/out     psel/penable/pready  one 32-bit register per 4 bytes
//
// Trigger, echo, calibrate, read and a poll with no capture go straight to emit.
// A capture poll emits if out of range or on a spike; else it commits, scans the
// median (up to MEDIAN_DEPTH entries, one a cycle), filters it and emits.
// One word is in work at a time; the next is taken as soon as the previous
// result is loaded into the output register, even if rsp_ready is low.
// Reset is synchronous and restores control, config and filter state registers.
module echo_range_filter #(
   parameter int MEDIAN_DEPTH = erf_pkg::MEDIAN_DEPTH
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [erf_pkg::OPCODE_W-1:0]      req_opcode,
   input  logic [erf_pkg::TIME_W-1:0]        req_edge_time,
   input  logic [erf_pkg::TIME_W-1:0]        req_now_ms,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [erf_pkg::DIST_W-1:0]        rsp_height_q8,
   output logic [erf_pkg::DIST_W-1:0]        rsp_distance_q8,
   output logic                              rsp_measure_valid,
   output logic                              rsp_busy_res,
   output logic                              rsp_fire_trigger,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [erf_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [erf_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [erf_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);

   localparam int DAT_W = erf_pkg::CSR_DATA_W;

   localparam logic [2:0] REG_MIN_PULSE = 3'd0;
   localparam logic [2:0] REG_MAX_PULSE = 3'd1;
   localparam logic [2:0] REG_TIMER_PER = 3'd2;
   localparam logic [2:0] REG_SPEED     = 3'd3;
   localparam logic [2:0] REG_SPIKE     = 3'd4;
   localparam logic [2:0] REG_ALPHA     = 3'd5;
   localparam logic [2:0] REG_TIMEOUT   = 3'd6;

   erf_pkg::cfg_type  cfg_ff;
   erf_pkg::cmd_type  cmd;
   erf_pkg::stat_type st;
   logic [2:0]        reg_idx;
   logic              csr_wr;

   assign reg_idx    = csr_paddr[4:2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_pulse_us       <= erf_pkg::RST_MIN_PULSE;
         cfg_ff.max_pulse_us       <= erf_pkg::RST_MAX_PULSE;
         cfg_ff.timer_period       <= erf_pkg::RST_TIMER_PER;
         cfg_ff.speed_factor_q8    <= erf_pkg::RST_SPEED;
         cfg_ff.spike_threshold_q8 <= erf_pkg::RST_SPIKE;
         cfg_ff.lpf_alpha_q8       <= erf_pkg::RST_ALPHA;
         cfg_ff.timeout_ms         <= erf_pkg::RST_TIMEOUT;
      end else if (csr_wr) begin
         unique case (reg_idx)
            REG_MIN_PULSE: cfg_ff.min_pulse_us <= csr_pwdata[erf_pkg::TIME_W-1:0];
            REG_MAX_PULSE: cfg_ff.max_pulse_us <= csr_pwdata[erf_pkg::TIME_W-1:0];
            REG_TIMER_PER: cfg_ff.timer_period <= csr_pwdata[erf_pkg::TIME_W-1:0];
            REG_SPEED:     cfg_ff.speed_factor_q8 <= csr_pwdata[erf_pkg::SPEED_W-1:0];
            REG_SPIKE:     cfg_ff.spike_threshold_q8 <= csr_pwdata[erf_pkg::DIST_W-1:0];
            REG_ALPHA:     cfg_ff.lpf_alpha_q8 <= csr_pwdata[erf_pkg::ALPHA_W-1:0];
            REG_TIMEOUT:   cfg_ff.timeout_ms <= csr_pwdata[erf_pkg::TIME_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_MIN_PULSE: csr_prdata = DAT_W'(cfg_ff.min_pulse_us);
         REG_MAX_PULSE: csr_prdata = DAT_W'(cfg_ff.max_pulse_us);
         REG_TIMER_PER: csr_prdata = DAT_W'(cfg_ff.timer_period);
         REG_SPEED:     csr_prdata = DAT_W'(cfg_ff.speed_factor_q8);
         REG_SPIKE:     csr_prdata = DAT_W'(cfg_ff.spike_threshold_q8);
         REG_ALPHA:     csr_prdata = DAT_W'(cfg_ff.lpf_alpha_q8);
         REG_TIMEOUT:   csr_prdata = DAT_W'(cfg_ff.timeout_ms);
         default:       csr_prdata = '0;
      endcase
   end

   erf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_opcode (req_opcode),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .cmd        (cmd),
      .st         (st)
   );

   erf_dp #(
      .MEDIAN_DEPTH (MEDIAN_DEPTH)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .req_edge_time     (req_edge_time),
      .req_now_ms        (req_now_ms),
      .cfg               (cfg_ff),
      .cmd               (cmd),
      .st                (st),
      .rsp_height_q8     (rsp_height_q8),
      .rsp_distance_q8   (rsp_distance_q8),
      .rsp_measure_valid (rsp_measure_valid),
      .rsp_busy_res      (rsp_busy_res),
      .rsp_fire_trigger  (rsp_fire_trigger)
   );

endmodule
